/* sv/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// property with an implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, prop)

`endif

`endif

/* sv/tps_pkg.sv */
`default_nettype none

package tps_pkg;

	localparam int NUM_PROCS   = 8;
	localparam int BUDGET_BITS = 8;
	localparam int PRIO_W      = 8;
	localparam int TICK_W      = 32;
	localparam int IDX_W       = $clog2(NUM_PROCS);
	localparam int CNT_W       = $clog2(NUM_PROCS + 1);

	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [BUDGET_BITS-1:0] budget_t;
	typedef logic [PRIO_W-1:0]      prio_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_FLAG = 2'd1,
		ACT_LOAD = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK,
		ST_SCAN1,
		ST_RELOAD,
		ST_SCAN2,
		ST_OUT_RD,
		ST_FIN
	} state_t;

	// one table entry as stored in the memory
	typedef struct packed {
		prio_t   prio;
		budget_t budget;
	} entry_t;

	// one memory access, read port and write port
	typedef struct packed {
		logic   rd_en;
		idx_t   rd_addr;
		logic   wr_en;
		idx_t   wr_addr;
		entry_t wr_data;
	} mem_req_t;

	// budget loaded from a priority, masked to the budget width
	function automatic budget_t budget_of_prio(prio_t p);
		return BUDGET_BITS'(p);
	endfunction

endpackage

`default_nettype wire

/* sv/tps_req_if.sv */
`default_nettype none

interface tps_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic       nested;
	logic [2:0] proc_index;
	logic       blocked;
	logic [7:0] priority_value;

	modport source (output valid, action, nested, proc_index, blocked, priority_value,
		input ready);
	modport sink (input valid, action, nested, proc_index, blocked, priority_value,
		output ready);
endinterface

`default_nettype wire

/* sv/tps_rsp_if.sv */
`default_nettype none

interface tps_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  current_proc;
	logic [7:0]  current_budget;
	logic [31:0] tick_count;
	logic        rescheduled;
	logic        none_runnable;

	modport source (output valid, current_proc, current_budget, tick_count, rescheduled,
		none_runnable, input ready);
	modport sink (input valid, current_proc, current_budget, tick_count, rescheduled,
		none_runnable, output ready);
endinterface

`default_nettype wire

/* sv/tps_cfg_if.sv */
`default_nettype none

interface tps_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] wrap_limit;

	modport source (output valid, wrap_limit, input ready);
	modport sink (input valid, wrap_limit, output ready);
endinterface

`default_nettype wire

/* sv/tps_table.sv */
`default_nettype none

module tps_table (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tps_pkg::mem_req_t mem_req,
	output tps_pkg::entry_t        rd_data
);
	import tps_pkg::*;

	entry_t               mem [NUM_PROCS];
	logic [NUM_PROCS-1:0] vld_q;
	entry_t               rd_raw_s1;
	logic                 rd_vld_s1;

	// storage and registered read port
	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			mem[mem_req.wr_addr] <= mem_req.wr_data;
		end
		if (mem_req.rd_en) begin
			rd_raw_s1 <= mem[mem_req.rd_addr];
		end
	end

	// per-entry valid bits, an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (mem_req.wr_en) begin
				vld_q[mem_req.wr_addr] <= 1'b1;
			end
			if (mem_req.rd_en) begin
				rd_vld_s1 <= vld_q[mem_req.rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_s1 ? rd_raw_s1 : '0;

endmodule

`default_nettype wire

/* sv/tick_priority_scheduler.sv */
// channel  dir  handshake          payload
// req      in   valid / ready      action, nested, proc_index, blocked, priority_value
// rsp      out  valid / ready      current_proc, current_budget, tick_count,
//                                  rescheduled, none_runnable
// cfg      in   valid / ready      wrap_limit
//
// flag, load and idle requests pass through OUT_RD and FIN; a tick reads its entry in TICK first.
// a selection sweeps the table memory once per pass; a full pick with reload and rescan
// makes three passes, SCAN1, RELOAD and SCAN2, before OUT_RD and FIN.
// the table memory has one read port and one write port.
// reset clears the tables through per-entry valid bits, no clearing pass needed.
// a result waits in the output register; the block holds its final state until that register is free.
`default_nettype none
`include "assert_macros.svh"

module tick_priority_scheduler (
	input wire logic  clk,
	input wire logic  arst_n,
	tps_req_if.sink   req,
	tps_rsp_if.source rsp,
	tps_cfg_if.sink   cfg
);
	import tps_pkg::*;

	state_t               state_q, state_d;
	idx_t                 cur_q;
	logic [TICK_W-1:0]    tick_q;
	logic [TICK_W-1:0]    max_q;
	logic                 nested_q;
	logic                 resched_q;
	logic                 none_q;
	cnt_t                 cnt_q;
	logic                 rd_s1;
	idx_t                 idx_s1;
	budget_t              best_q;
	idx_t                 pick_q;
	logic [NUM_PROCS-1:0] blocked_q;

	logic                 rsp_vld_q;
	logic [2:0]           rsp_proc_q;
	logic [7:0]           rsp_budget_q;
	logic [TICK_W-1:0]    rsp_tick_q;
	logic                 rsp_resched_q;
	logic                 rsp_none_q;

	mem_req_t             mem_req;
	entry_t               rd_data;

	logic                 accept;
	action_t              act;
	logic                 idx_ok;
	idx_t                 idx_in;
	logic                 in_sweep;
	logic                 issue;
	logic                 sweep_end;
	logic                 is_scan;
	budget_t              dec_b;
	logic [TICK_W:0]      tick_inc;
	logic [TICK_W-1:0]    tick_next;
	logic                 rsp_free;

	tps_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	// request decode
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign act       = action_t'(req.action);
	assign idx_ok    = 32'(req.proc_index) < 32'(NUM_PROCS);
	assign idx_in    = req.proc_index[IDX_W-1:0];
	assign cfg.ready = 1'b1;

	// sweep control
	assign in_sweep  = (state_q == ST_SCAN1) || (state_q == ST_RELOAD)
		|| (state_q == ST_SCAN2);
	assign is_scan   = (state_q == ST_SCAN1) || (state_q == ST_SCAN2);
	assign issue     = in_sweep && (cnt_q < CNT_W'(NUM_PROCS));
	assign sweep_end = in_sweep && (cnt_q == CNT_W'(NUM_PROCS)) && !rd_s1;

	// datapath helpers
	assign dec_b     = (rd_data.budget != '0) ? rd_data.budget - 1'b1 : '0;
	assign tick_inc  = {1'b0, tick_q} + 1'b1;
	assign tick_next = (tick_inc >= {1'b0, max_q}) ? '0 : tick_inc[TICK_W-1:0];
	assign rsp_free  = !rsp_vld_q || rsp.ready;

	// next state and memory access
	always_comb begin
		state_d = state_q;
		mem_req = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (act)
						ACT_TICK: begin
							mem_req.rd_en   = 1'b1;
							mem_req.rd_addr = cur_q;
							state_d         = ST_TICK;
						end
						ACT_LOAD: begin
							mem_req.wr_en          = idx_ok;
							mem_req.wr_addr        = idx_in;
							mem_req.wr_data.prio   = req.priority_value;
							mem_req.wr_data.budget = budget_of_prio(req.priority_value);
							state_d                = ST_OUT_RD;
						end
						default: begin
							state_d = ST_OUT_RD;
						end
					endcase
				end
			end
			ST_TICK: begin
				mem_req.wr_en          = (rd_data.budget != '0);
				mem_req.wr_addr        = cur_q;
				mem_req.wr_data.prio   = rd_data.prio;
				mem_req.wr_data.budget = dec_b;
				state_d = (!nested_q && dec_b == '0) ? ST_SCAN1 : ST_OUT_RD;
			end
			ST_SCAN1, ST_RELOAD, ST_SCAN2: begin
				mem_req.rd_en   = issue;
				mem_req.rd_addr = cnt_q[IDX_W-1:0];
				if (state_q == ST_RELOAD && rd_s1 && !blocked_q[idx_s1]) begin
					mem_req.wr_en          = 1'b1;
					mem_req.wr_addr        = idx_s1;
					mem_req.wr_data.prio   = rd_data.prio;
					mem_req.wr_data.budget = budget_of_prio(rd_data.prio);
				end
				if (sweep_end) begin
					case (state_q)
						ST_SCAN1: state_d = (best_q != '0) ? ST_OUT_RD : ST_RELOAD;
						ST_RELOAD: state_d = ST_SCAN2;
						default: state_d = ST_OUT_RD;
					endcase
				end
			end
			ST_OUT_RD: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = cur_q;
				state_d         = ST_FIN;
			end
			ST_FIN: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// scheduler control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			tick_q    <= '0;
			max_q     <= '1;
			nested_q  <= 1'b0;
			resched_q <= 1'b0;
			none_q    <= 1'b0;
			cnt_q     <= '0;
			rd_s1     <= 1'b0;
			idx_s1    <= '0;
			best_q    <= '0;
			pick_q    <= '0;
			blocked_q <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				max_q <= cfg.wrap_limit;
			end
			if (accept) begin
				nested_q  <= req.nested;
				resched_q <= 1'b0;
				none_q    <= 1'b0;
				if (act == ACT_TICK) begin
					tick_q <= tick_next;
				end
				if (act == ACT_FLAG && idx_ok) begin
					blocked_q[idx_in] <= req.blocked;
				end
			end
			if (state_q == ST_TICK && state_d == ST_SCAN1) begin
				resched_q <= 1'b1;
			end
			// sweep counter and read pipeline
			rd_s1  <= issue;
			idx_s1 <= cnt_q[IDX_W-1:0];
			if (state_d != state_q) begin
				cnt_q  <= '0;
				best_q <= '0;
			end else begin
				if (issue) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (is_scan && rd_s1 && !blocked_q[idx_s1] && rd_data.budget > best_q) begin
					best_q <= rd_data.budget;
					pick_q <= idx_s1;
				end
			end
			// end of a scan pass
			if (sweep_end && is_scan) begin
				if (best_q != '0) begin
					cur_q <= pick_q;
				end else if (state_q == ST_SCAN2) begin
					none_q <= 1'b1;
				end
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (state_q == ST_FIN && rsp_free) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && rsp_free) begin
			rsp_proc_q    <= 3'(cur_q);
			rsp_budget_q  <= 8'(rd_data.budget);
			rsp_tick_q    <= tick_q;
			rsp_resched_q <= resched_q;
			rsp_none_q    <= none_q;
		end
	end

	assign rsp.valid          = rsp_vld_q;
	assign rsp.current_proc   = rsp_proc_q;
	assign rsp.current_budget = rsp_budget_q;
	assign rsp.tick_count     = rsp_tick_q;
	assign rsp.rescheduled    = rsp_resched_q;
	assign rsp.none_runnable  = rsp_none_q;

	// checks
	`ASSERT_ALWAYS(a_cur_range, clk, arst_n, 32'(cur_q) < 32'(NUM_PROCS))
	`ASSERT_ALWAYS(a_none_needs_resched, clk, arst_n, !(none_q && !resched_q))
	`ASSERT_ALWAYS(a_no_same_entry_rw, clk, arst_n,
		!(mem_req.rd_en && mem_req.wr_en && mem_req.rd_addr == mem_req.wr_addr))
	`ASSERT_IMPLIES(a_rsp_from_fin, clk, arst_n, $rose(rsp_vld_q) |-> $past(state_q == ST_FIN))

endmodule

`default_nettype wire

/* verif/tick_priority_scheduler_tb.sv */
`timescale 1ns / 1ps

module tick_priority_scheduler_tb;
	import tps_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_ITEMS = 138;

	typedef struct packed {
		action_t action;
		logic    nested;
		idx_t    proc_index;
		logic    blocked;
		prio_t   priority_value;
	} sched_req_t;

	typedef struct packed {
		idx_t        current_proc;
		budget_t     current_budget;
		logic [31:0] tick_count;
		logic        rescheduled;
		logic        none_runnable;
	} sched_rsp_t;

	logic clk;
	logic arst_n;

	tps_req_if req_if ();
	tps_rsp_if rsp_if ();
	tps_cfg_if cfg_if ();

	tick_priority_scheduler u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if),
		.cfg   (cfg_if)
	);

	// scheduler state as the testbench tracks it
	budget_t     mdl_budget  [NUM_PROCS] = '{default: '0};
	prio_t       mdl_prio    [NUM_PROCS] = '{default: '0};
	logic        mdl_blocked [NUM_PROCS] = '{default: 1'b0};
	idx_t        mdl_cur = '0;
	logic [31:0] mdl_ticks = '0;
	logic [31:0] mdl_wrap_limit = 32'hFFFF_FFFF;

	sched_req_t pending_reqs[$];
	sched_rsp_t expected_sched[$];
	sched_req_t req_on_bus;

	int items_queued = 0;
	int results_seen = 0;
	int err_count = 0;
	int idle_pct = 15;
	int quiet_cycles = 0;

	// largest runnable budget, lowest index on ties
	function automatic bit pick_runnable();
		budget_t best;
		best = '0;
		for (int i = 0; i < NUM_PROCS; i++) begin
			if (!mdl_blocked[i] && mdl_budget[i] > best) begin
				best = mdl_budget[i];
				mdl_cur = idx_t'(i);
			end
		end
		return best != '0;
	endfunction

	// apply one request to the tracked state, return the result it should give
	function automatic sched_rsp_t step_scheduler(sched_req_t r);
		sched_rsp_t o;
		logic [32:0] nxt;
		idx_t c;
		o = '0;
		case (r.action)
			ACT_TICK: begin
				nxt = {1'b0, mdl_ticks} + 33'd1;
				mdl_ticks = (nxt >= {1'b0, mdl_wrap_limit}) ? '0 : nxt[31:0];
				c = mdl_cur;
				if (mdl_budget[c] != '0)
					mdl_budget[c] = mdl_budget[c] - 1'b1;
				if (!r.nested && mdl_budget[c] == '0) begin
					o.rescheduled = 1'b1;
					if (!pick_runnable()) begin
						// all runnable budgets spent: refill from priorities and retry
						for (int i = 0; i < NUM_PROCS; i++)
							if (!mdl_blocked[i])
								mdl_budget[i] = budget_t'(mdl_prio[i]);
						o.none_runnable = !pick_runnable();
					end
				end
			end
			ACT_FLAG: begin
				mdl_blocked[r.proc_index] = r.blocked;
			end
			ACT_LOAD: begin
				mdl_prio[r.proc_index] = r.priority_value;
				mdl_budget[r.proc_index] = budget_t'(r.priority_value);
			end
			default: ;
		endcase
		o.current_proc = mdl_cur;
		o.current_budget = mdl_budget[mdl_cur];
		o.tick_count = mdl_ticks;
		return o;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			err_count++;
		end
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// request driver
	always @(posedge clk) begin
		logic launch;
		if (arst_n) begin
			if (req_if.valid && req_if.ready)
				expected_sched.push_back(step_scheduler(req_on_bus));
			if (!req_if.valid || req_if.ready) begin
				launch = pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct;
				if (launch) begin
					req_on_bus = pending_reqs.pop_front();
					req_if.action <= req_on_bus.action;
					req_if.nested <= req_on_bus.nested;
					req_if.proc_index <= req_on_bus.proc_index;
					req_if.blocked <= req_on_bus.blocked;
					req_if.priority_value <= req_on_bus.priority_value;
				end
				req_if.valid <= launch;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		sched_rsp_t want;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (expected_sched.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual proc %0d budget %0d",
						$time, rsp_if.current_proc, rsp_if.current_budget);
					err_count++;
				end else begin
					want = expected_sched.pop_front();
					check_field("current_proc", want.current_proc, rsp_if.current_proc);
					check_field("current_budget", want.current_budget, rsp_if.current_budget);
					check_field("tick_count", want.tick_count, rsp_if.tick_count);
					check_field("rescheduled", want.rescheduled, rsp_if.rescheduled);
					check_field("none_runnable", want.none_runnable, rsp_if.none_runnable);
					results_seen++;
				end
			end
			rsp_if.ready <= $urandom_range(0, 99) >= idle_pct;
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
					|| (cfg_if.valid && cfg_if.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic queue_req(action_t a, logic n, idx_t idx, logic blk, prio_t p);
		sched_req_t r;
		r.action = a;
		r.nested = n;
		r.proc_index = idx;
		r.blocked = blk;
		r.priority_value = p;
		pending_reqs.push_back(r);
		items_queued++;
	endtask

	task automatic wait_all_done();
		while (results_seen != items_queued)
			@(posedge clk);
	endtask

	task automatic write_wrap_limit(logic [31:0] v);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.wrap_limit <= v;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		mdl_wrap_limit = v;
		cfg_if.valid <= 1'b0;
	endtask

	// stimulus
	initial begin
		logic [31:0] phase_max [6];
		sched_req_t r;
		int pick;

		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.action = ACT_TICK;
		req_if.nested = 1'b0;
		req_if.proc_index = '0;
		req_if.blocked = 1'b0;
		req_if.priority_value = '0;
		rsp_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.wrap_limit = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, short wrap period
		write_wrap_limit(32'd5);
		// empty table: nothing to pick
		queue_req(ACT_TICK, 1'b0, 3'd0, 1'b0, 8'd0);
		queue_req(ACT_NONE, 1'b1, 3'd5, 1'b1, 8'hAA);
		queue_req(ACT_LOAD, 1'b0, 3'd0, 1'b0, 8'd255);
		queue_req(ACT_LOAD, 1'b0, 3'd7, 1'b0, 8'd255);
		queue_req(ACT_LOAD, 1'b0, 3'd2, 1'b0, 8'd255);
		queue_req(ACT_LOAD, 1'b0, 3'd3, 1'b0, 8'd1);
		queue_req(ACT_LOAD, 1'b0, 3'd5, 1'b0, 8'd0);
		queue_req(ACT_TICK, 1'b1, 3'd0, 1'b0, 8'd0);
		queue_req(ACT_TICK, 1'b0, 3'd0, 1'b0, 8'd0);
		// exhaust current, tie between two full budgets
		queue_req(ACT_LOAD, 1'b0, 3'd0, 1'b0, 8'd1);
		queue_req(ACT_TICK, 1'b0, 3'd0, 1'b0, 8'd0);
		// nested tick reaching zero must not reschedule
		queue_req(ACT_LOAD, 1'b0, 3'd2, 1'b0, 8'd1);
		queue_req(ACT_TICK, 1'b1, 3'd0, 1'b0, 8'd0);
		queue_req(ACT_TICK, 1'b0, 3'd0, 1'b0, 8'd0);
		// blocked current keeps running until spent
		queue_req(ACT_FLAG, 1'b0, 3'd7, 1'b1, 8'd0);
		queue_req(ACT_LOAD, 1'b0, 3'd7, 1'b0, 8'd1);
		queue_req(ACT_TICK, 1'b0, 3'd0, 1'b0, 8'd0);
		// all runnable budgets spent: refill and repick
		queue_req(ACT_TICK, 1'b0, 3'd0, 1'b0, 8'd0);
		// block the rest of the nonzero entries: nothing runnable after refill
		queue_req(ACT_FLAG, 1'b0, 3'd0, 1'b1, 8'd0);
		queue_req(ACT_FLAG, 1'b0, 3'd2, 1'b1, 8'd0);
		queue_req(ACT_FLAG, 1'b0, 3'd3, 1'b1, 8'd0);
		queue_req(ACT_TICK, 1'b0, 3'd0, 1'b0, 8'd0);
		queue_req(ACT_FLAG, 1'b0, 3'd0, 1'b0, 8'd0);

		// random phases, each starting from a drained block
		phase_max[0] = 32'd1;
		phase_max[1] = 32'd0;
		phase_max[2] = 32'hFFFF_FFFF;
		phase_max[3] = $urandom_range(2, 40);
		phase_max[4] = $urandom;
		phase_max[5] = 32'd9;
		for (int ph = 0; ph < 6; ph++) begin
			wait_all_done();
			write_wrap_limit(phase_max[ph]);
			// one phase runs with no idling on either side
			idle_pct = (ph == 2) ? 0 : 15;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 55)
					r.action = ACT_TICK;
				else if (pick < 72)
					r.action = ACT_LOAD;
				else if (pick < 97)
					r.action = ACT_FLAG;
				else
					r.action = ACT_NONE;
				r.nested = ($urandom_range(0, 4) == 0);
				r.proc_index = idx_t'($urandom_range(0, NUM_PROCS - 1));
				r.blocked = ($urandom_range(0, 2) == 0);
				// mostly small priorities so budgets run out often
				r.priority_value = ($urandom_range(0, 3) != 0) ? prio_t'($urandom_range(0, 6))
					: prio_t'($urandom_range(0, 255));
				queue_req(r.action, r.nested, r.proc_index, r.blocked, r.priority_value);
			end
		end

		wait_all_done();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && expected_sched.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* sim.f */
+incdir+sv
sv/tps_pkg.sv
sv/tps_req_if.sv
sv/tps_rsp_if.sv
sv/tps_cfg_if.sv
sv/tps_table.sv
sv/tick_priority_scheduler.sv
verif/tick_priority_scheduler_tb.sv
